// File: src/tvpc_pkg.sv
// ----------------------------------------------------------------------------
// tvpc_pkg: shared definitions for the typed value prefix comparator
// Holds the type, operator and outcome codes, and the pipeline stage words.
// ----------------------------------------------------------------------------
`default_nettype none

package tvpc_pkg;

   localparam int CmdW    = 3;
   localparam int TypeW   = 4;
   localparam int HalfW   = 64;
   localparam int AddrW   = 128;
   localparam int PfxW    = 8;
   localparam int OutW    = 2;

   localparam logic [PfxW-1:0] V4_BITS = 8'd32;
   localparam logic [PfxW-1:0] V6_BITS = 8'd128;

   // Value type codes.
   localparam logic [TypeW-1:0] T_BYTE   = 4'd0;
   localparam logic [TypeW-1:0] T_SHORT  = 4'd1;
   localparam logic [TypeW-1:0] T_DATE   = 4'd2;
   localparam logic [TypeW-1:0] T_U32    = 4'd3;
   localparam logic [TypeW-1:0] T_S32    = 4'd4;
   localparam logic [TypeW-1:0] T_U64    = 4'd5;
   localparam logic [TypeW-1:0] T_ETHER  = 4'd6;
   localparam logic [TypeW-1:0] T_IFID   = 4'd7;
   localparam logic [TypeW-1:0] T_IP4    = 4'd8;
   localparam logic [TypeW-1:0] T_IP4PFX = 4'd9;
   localparam logic [TypeW-1:0] T_IP6    = 4'd10;
   localparam logic [TypeW-1:0] T_IP6PFX = 4'd11;

   // Operator codes.
   localparam logic [CmdW-1:0] OP_EQ = 3'd0;
   localparam logic [CmdW-1:0] OP_NE = 3'd1;
   localparam logic [CmdW-1:0] OP_LT = 3'd2;
   localparam logic [CmdW-1:0] OP_GT = 3'd3;
   localparam logic [CmdW-1:0] OP_LE = 3'd4;
   localparam logic [CmdW-1:0] OP_GE = 3'd5;

   // Outcome codes.
   localparam logic [OutW-1:0] OUT_FALSE = 2'd0;
   localparam logic [OutW-1:0] OUT_TRUE  = 2'd1;
   localparam logic [OutW-1:0] OUT_ERROR = 2'd2;

   // Word held after decode.
   typedef struct packed {
      logic [CmdW-1:0]  op;
      logic             err;
      logic             pfx;
      logic             len_eq;
      logic             a_shorter;
      logic [PfxW-1:0]  common;
      logic [AddrW-1:0] a_val;
      logic [AddrW-1:0] b_val;
   } s1_word_type;

   // Word held after the partial compares.
   typedef struct packed {
      logic [CmdW-1:0] op;
      logic            err;
      logic            pfx;
      logic            len_eq;
      logic            a_shorter;
      logic            eq_hi;
      logic            eq_lo;
      logic            lt_hi;
      logic            lt_lo;
      logic            lead_ok;
   } s2_word_type;

endpackage

`default_nettype wire

// File: src/typed_value_prefix_compare.sv
// ----------------------------------------------------------------------------
// typed_value_prefix_compare: typed scalar and address prefix comparator
// Three-stage pipeline: type decode, split compares, outcome selection.
// ----------------------------------------------------------------------------
// Usage: a word on the req_ channel carries an operator and two typed values
// with their prefix lengths. For every accepted word exactly one word leaves
// on the rsp_ channel with outcome false, true or error, in order.
// A word is taken when req_valid is high and req_stall is low; a result is
// taken when rsp_valid is high and rsp_stall is low.
// rsp_valid rises once the word has passed the decode and compare registers
// into the output register. One word is accepted every cycle while req_stall is low;
// each of the three register stages, decode, the 64-bit half compares with
// the prefix mask, and the output register, holds one word.
// When the receiver stalls, the output register holds its word and the
// stages behind it keep filling; req_stall rises only once all three stages
// hold a word. Reset empties the pipeline; no word is lost or repeated
// across a stall.
// ----------------------------------------------------------------------------
`default_nettype none

module typed_value_prefix_compare (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic [tvpc_pkg::CmdW-1:0]   req_command,
   input  wire logic [tvpc_pkg::TypeW-1:0]  req_a_type,
   input  wire logic [tvpc_pkg::HalfW-1:0]  req_a_value_high,
   input  wire logic [tvpc_pkg::HalfW-1:0]  req_a_value_low,
   input  wire logic [tvpc_pkg::PfxW-1:0]   req_a_prefix_length,
   input  wire logic [tvpc_pkg::TypeW-1:0]  req_b_type,
   input  wire logic [tvpc_pkg::HalfW-1:0]  req_b_value_high,
   input  wire logic [tvpc_pkg::HalfW-1:0]  req_b_value_low,
   input  wire logic [tvpc_pkg::PfxW-1:0]   req_b_prefix_length,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic [tvpc_pkg::OutW-1:0]        rsp_outcome
);
   import tvpc_pkg::*;

   logic             s1_valid_ff, s1_valid_in;
   s1_word_type      s1_ff, s1_in;
   logic             s2_valid_ff, s2_valid_in;
   s2_word_type      s2_ff, s2_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [OutW-1:0]  rsp_outcome_ff, rsp_outcome_in;

   logic en1, en2, en3;

   // A stage advances when it is empty or the stage after it advances.
   assign en3       = !rsp_valid_ff || !rsp_stall;
   assign en2       = !s2_valid_ff || en3;
   assign en1       = !s1_valid_ff || en2;
   assign req_stall = !en1;

   // ---------------- Stage 1: type decode ----------------
   logic [PfxW-1:0]  a_len, b_len;
   logic [AddrW-1:0] a_scal, b_scal;

   function automatic logic [AddrW-1:0] scalar_value(
      input logic [TypeW-1:0] t, input logic [HalfW-1:0] hi, input logic [HalfW-1:0] lo);
      logic [AddrW-1:0] v;
      v = '0;
      case (t) inside
         T_BYTE:                 v[7:0]  = lo[7:0];
         T_SHORT:                v[15:0] = lo[15:0];
         T_DATE, T_U32, T_IP4:   v[31:0] = lo[31:0];
         // Flipping the sign bit turns signed order into unsigned order.
         T_S32:                  v[31:0] = {~lo[31], lo[30:0]};
         T_U64, T_IFID:          v[63:0] = lo;
         T_ETHER:                v[47:0] = lo[47:0];
         T_IP6:                  v       = {hi, lo};
         default:                v       = '0;
      endcase
      return v;
   endfunction

   always_comb begin
      s1_in           = '0;
      s1_in.op        = req_command;
      a_len           = req_a_prefix_length;
      b_len           = req_b_prefix_length;
      a_scal          = scalar_value(req_a_type, req_a_value_high, req_a_value_low);
      b_scal          = scalar_value(req_b_type, req_b_value_high, req_b_value_low);
      if (req_a_type == T_IP4PFX || req_b_type == T_IP4PFX) begin
         // IPv4 is placed at the top of the word so the prefix mask is shared.
         s1_in.pfx   = 1'b1;
         if (req_a_type == T_IP4) a_len = V4_BITS;
         if (req_b_type == T_IP4) b_len = V4_BITS;
         s1_in.err   = !((req_a_type == T_IP4 || req_a_type == T_IP4PFX) &&
                         (req_b_type == T_IP4 || req_b_type == T_IP4PFX)) ||
                       a_len > V4_BITS || b_len > V4_BITS;
         s1_in.a_val = {req_a_value_low[31:0], 96'd0};
         s1_in.b_val = {req_b_value_low[31:0], 96'd0};
      end else if (req_a_type == T_IP6PFX || req_b_type == T_IP6PFX) begin
         s1_in.pfx   = 1'b1;
         if (req_a_type == T_IP6) a_len = V6_BITS;
         if (req_b_type == T_IP6) b_len = V6_BITS;
         s1_in.err   = !((req_a_type == T_IP6 || req_a_type == T_IP6PFX) &&
                         (req_b_type == T_IP6 || req_b_type == T_IP6PFX)) ||
                       a_len > V6_BITS || b_len > V6_BITS;
         s1_in.a_val = {req_a_value_high, req_a_value_low};
         s1_in.b_val = {req_b_value_high, req_b_value_low};
      end else begin
         s1_in.pfx   = 1'b0;
         s1_in.err   = (req_a_type != req_b_type) || (req_a_type > T_IP6PFX);
         s1_in.a_val = a_scal;
         s1_in.b_val = b_scal;
      end
      s1_in.len_eq    = (a_len == b_len);
      s1_in.a_shorter = (a_len < b_len);
      s1_in.common    = (a_len < b_len) ? a_len : b_len;
   end

   assign s1_valid_in = en1 ? req_valid : s1_valid_ff;

   // ---------------- Stage 2: split compares and prefix match ----------------
   logic [AddrW-1:0] lead_mask;
   logic [AddrW-1:0] diff;

   always_comb begin
      lead_mask       = ~({AddrW{1'b1}} >> s1_ff.common);
      diff            = s1_ff.a_val ^ s1_ff.b_val;
      s2_in.op        = s1_ff.op;
      s2_in.err       = s1_ff.err;
      s2_in.pfx       = s1_ff.pfx;
      s2_in.len_eq    = s1_ff.len_eq;
      s2_in.a_shorter = s1_ff.a_shorter;
      s2_in.eq_hi     = s1_ff.a_val[AddrW-1:HalfW] == s1_ff.b_val[AddrW-1:HalfW];
      s2_in.eq_lo     = s1_ff.a_val[HalfW-1:0] == s1_ff.b_val[HalfW-1:0];
      s2_in.lt_hi     = s1_ff.a_val[AddrW-1:HalfW] < s1_ff.b_val[AddrW-1:HalfW];
      s2_in.lt_lo     = s1_ff.a_val[HalfW-1:0] < s1_ff.b_val[HalfW-1:0];
      s2_in.lead_ok   = ~|(diff & lead_mask);
   end

   assign s2_valid_in = en2 ? s1_valid_ff : s2_valid_ff;

   // ---------------- Stage 3: outcome selection ----------------
   logic same, less, hit;

   always_comb begin
      same = s2_ff.eq_hi && s2_ff.eq_lo;
      less = s2_ff.lt_hi || (s2_ff.eq_hi && s2_ff.lt_lo);
      hit  = 1'b0;
      if (s2_ff.pfx) begin
         if (s2_ff.len_eq) begin
            hit = same && (s2_ff.op == OP_EQ || s2_ff.op == OP_LE || s2_ff.op == OP_GE);
         end else begin
            case (s2_ff.op) inside
               OP_EQ:        hit = 1'b0;
               OP_NE:        hit = 1'b1;
               OP_LT, OP_LE: hit = !s2_ff.a_shorter && s2_ff.lead_ok;
               OP_GT, OP_GE: hit = s2_ff.a_shorter && s2_ff.lead_ok;
               default:      hit = 1'b0;
            endcase
         end
      end else begin
         case (s2_ff.op)
            OP_EQ:   hit = same;
            OP_NE:   hit = !same;
            OP_LT:   hit = less;
            OP_GT:   hit = !less && !same;
            OP_LE:   hit = less || same;
            OP_GE:   hit = !less;
            default: hit = 1'b0;
         endcase
      end
      if (s2_ff.err) rsp_outcome_in = OUT_ERROR;
      else           rsp_outcome_in = hit ? OUT_TRUE : OUT_FALSE;
   end

   assign rsp_valid_in = en3 ? s2_valid_ff : rsp_valid_ff;

   // ---------------- Registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) s1_ff          <= s1_in;
      if (en2) s2_ff          <= s2_in;
      if (en3) rsp_outcome_ff <= rsp_outcome_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_outcome = rsp_outcome_ff;

   // ---------------- Assertions ----------------
   a_outcome_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_outcome == OUT_FALSE || rsp_outcome == OUT_TRUE ||
                     rsp_outcome == OUT_ERROR))
      else $error("result word carries an unused outcome code");

   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && s2_valid_ff && rsp_valid_ff))
      else $error("input stalled while a pipeline stage is empty");

   a_error_passes: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && en3 && s2_ff.err) |=> (rsp_valid && rsp_outcome == OUT_ERROR))
      else $error("error flag lost in the last stage");

   a_pfx_eq_len_ne: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && en3 && !s2_ff.err && s2_ff.pfx && s2_ff.len_eq &&
       s2_ff.op == OP_NE) |=> (rsp_outcome == OUT_FALSE))
      else $error("prefix ne with equal lengths must be false");

endmodule

`default_nettype wire
